### sv/differential_drive_odometry_assert.svh
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// same-cycle implication
`define DDO_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DDO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/ddo_pkg.sv
package ddo_pkg;

   typedef enum logic [4:0] {
      S_IDLE,
      S_PREP,
      S_MUL_P,
      S_MUL_N,
      S_CORDIC,
      S_TRIG,
      S_MX_LO,
      S_MX_HI,
      S_MY_LO,
      S_MY_HI,
      S_POS_Y,
      S_DIV1,
      S_RK_LO,
      S_RK_HI,
      S_DIV2,
      S_QK0,
      S_QK1,
      S_QK2,
      S_TURN,
      S_DONE
   } state_type;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;
   localparam int UPPER_BITS     = 23;
   localparam int LOWER_BITS     = 24;
   localparam int DPP_BITS       = 24;
   localparam int WD_BITS        = 24;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ENCODER_UPPER      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ENCODER_LOWER      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DISTANCE_PER_PULSE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WHEEL_DISTANCE     = 3'd3;

   localparam logic [UPPER_BITS-1:0] UPPER_RESET = 23'd8388607;
   localparam logic [LOWER_BITS-1:0] LOWER_RESET = 24'h800000;
   localparam logic [DPP_BITS-1:0]   DPP_RESET   = 24'd1024;
   localparam logic [WD_BITS-1:0]    WD_RESET    = 24'd65536;

   // 2^56 / (2*pi) split at bit 32
   localparam logic [31:0] KF_LO = 32'd3683881219;
   localparam logic [21:0] KF_HI = 22'd2670176;
   localparam int KF_QUOT_BITS   = 54;

   localparam int TRIG_BITS  = 34;
   localparam int ANGLE_BITS = 33;
   localparam logic signed [TRIG_BITS-1:0] CORDIC_X0 = 34'sd652032874;

   localparam logic [29:0] ATAN_TABLE [0:31] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
      30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
      30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
      30'd20,        30'd10,        30'd5,         30'd3,        30'd1,
      30'd1,         30'd0
   };

endpackage

### sv/differential_drive_odometry.sv
// each input transaction passes through one shared multiplier, the cordic step loop
// and a bit-serial restoring divider before its result is presented
// one transaction at a time, accepted only in idle; a waiting result does not block input
// zero wheel distance skips the divider
// reset: synchronous, active high; clears state, positions, heading and loads register defaults
`include "differential_drive_odometry_assert.svh"

module differential_drive_odometry
   import ddo_pkg::*;
#(
   parameter int COUNT_BITS    = 24,
   parameter int POSITION_BITS = 32,
   parameter int CORDIC_STEPS  = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // left_count, right_count
   input  logic [((2*COUNT_BITS+7)/8)*8-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // x_position, y_position, heading
   output logic [95:0]                   rsp_tdata,
   // encoder_reset
   output logic                          rsp_tuser,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int SUM_W = COUNT_BITS + 2;
   localparam int PW    = SUM_W + DPP_BITS;
   localparam int DMW   = PW - 8;
   localparam int MA    = SUM_W > 32 ? SUM_W : 32;
   localparam int PRW   = MA + 32;
   localparam int SW    = DMW + 2;
   localparam int EW    = (POSITION_BITS > SW ? POSITION_BITS : SW) + 2;
   localparam int EXT_W = EW > 32 ? EW : 32;
   localparam int DQW   = PW > KF_QUOT_BITS ? PW : KF_QUOT_BITS;
   localparam int IW    = $clog2(DQW);
   localparam int LW    = COUNT_BITS + 5 > 28 ? COUNT_BITS + 5 : 28;
   localparam int RK_W  = WD_BITS + 32;
   localparam int NK_W  = WD_BITS + KF_QUOT_BITS;

   localparam logic signed [LW-1:0] NINE   = 9;
   localparam logic signed [LW-1:0] TEN    = 10;
   localparam logic signed [LW-1:0] ELEVEN = 11;

   state_type state_ff, state_in;
   logic [IW-1:0] iter_ff, iter_in;

   logic [UPPER_BITS-1:0]        upper_ff, upper_in;
   logic signed [LOWER_BITS-1:0] lower_ff, lower_in;
   logic [DPP_BITS-1:0]          dpp_ff, dpp_in;
   logic [WD_BITS-1:0]           wd_ff, wd_in;

   logic signed [COUNT_BITS-1:0]    prev_left_ff, prev_left_in, prev_right_ff, prev_right_in;
   logic signed [POSITION_BITS-1:0] x_pos_ff, x_pos_in, y_pos_ff, y_pos_in;
   logic [31:0]                     heading_ff, heading_in;

   logic signed [COUNT_BITS-1:0] left_ff, left_in, right_ff, right_in;
   logic [SUM_W-1:0]  sum_mag_ff, sum_mag_in, diff_mag_ff, diff_mag_in;
   logic              sum_neg_ff, sum_neg_in, diff_neg_ff, diff_neg_in;
   logic              rst_ff, rst_in;
   logic [DMW-1:0]    dm_ff, dm_in;
   logic [PW-1:0]     n_mag_ff, n_mag_in;
   logic              fold_ff, fold_in;
   logic signed [TRIG_BITS-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ANGLE_BITS-1:0] cz_ff, cz_in;
   logic [31:0]       s_mag_ff, s_mag_in, c_mag_ff, c_mag_in;
   logic              s_neg_ff, s_neg_in, c_neg_ff, c_neg_in;
   logic [PRW-30:0]   acc_ff, acc_in;
   logic [SW-1:0]     scale_ff, scale_in;
   logic [WD_BITS-1:0] rem_ff, rem_in;
   logic [DQW-1:0]    dq_ff, dq_in;
   logic [PW-1:0]     q_ff, q_in;
   logic [RK_W-1:0]   rk_ff, rk_in;
   logic [63:0]       t_ff, t_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   logic [MA-1:0]  mul_a;
   logic [31:0]    mul_b;
   logic [PRW-1:0] mul_p;

   logic signed [COUNT_BITS:0]  dl, dr;
   logic signed [SUM_W-1:0]     sum_v, diff_v;
   logic [31:0]                 hr;
   logic signed [TRIG_BITS-1:0] xs, ys, s_val, c_val;
   logic signed [ANGLE_BITS-1:0] atan_val;
   logic [PW:0]                 p_round;
   logic [PRW:0]                q30_round;
   logic [WD_BITS:0]            div_t;
   logic                        div_ge;
   logic [WD_BITS-1:0]          div_rem;
   logic [DQW-1:0]              div_dq;
   logic [NK_W-1:0]             nk;
   logic signed [EW-1:0]        pos_old, pos_delta, pos_sum;
   logic                        pos_sub;
   logic [63:0]                 t_round;
   logic [31:0]                 turn_mag, turn;
   logic signed [EXT_W-1:0]     x_ext, y_ext;

   function automatic logic near_limit(input logic signed [COUNT_BITS-1:0] e,
                                       input logic [UPPER_BITS-1:0] upper,
                                       input logic signed [LOWER_BITS-1:0] lower);
      logic signed [LW-1:0] e10, u9, l9, l11;
      e10 = LW'(e) * TEN;
      u9  = $signed(LW'(upper)) * NINE;
      l9  = LW'(lower) * NINE;
      l11 = LW'(lower) * ELEVEN;
      return (e10 > u9) || (e10 < l9) || (e10 < l11);
   endfunction

   function automatic logic signed [POSITION_BITS-1:0] sat_pos(input logic signed [EW-1:0] v);
      if (&v[EW-1:POSITION_BITS-1] || ~|v[EW-1:POSITION_BITS-1]) begin
         return v[POSITION_BITS-1:0];
      end
      return v[EW-1] ? {1'b1, {(POSITION_BITS-1){1'b0}}} : {1'b0, {(POSITION_BITS-1){1'b1}}};
   endfunction

   assign mul_p = PRW'(mul_a) * PRW'(mul_b);

   assign dl     = (COUNT_BITS+1)'(left_ff) - (COUNT_BITS+1)'(prev_left_ff);
   assign dr     = (COUNT_BITS+1)'(right_ff) - (COUNT_BITS+1)'(prev_right_ff);
   assign sum_v  = SUM_W'(dr) + SUM_W'(dl);
   assign diff_v = SUM_W'(dr) - SUM_W'(dl);
   assign hr     = heading_ff ^ {(heading_ff[31] ^ heading_ff[30]), 31'd0};

   assign xs       = cx_ff >>> iter_ff[4:0];
   assign ys       = cy_ff >>> iter_ff[4:0];
   assign atan_val = ANGLE_BITS'(ATAN_TABLE[iter_ff[4:0]]);
   assign s_val    = fold_ff ? -cy_ff : cy_ff;
   assign c_val    = fold_ff ? -cx_ff : cx_ff;

   assign p_round   = {1'b0, mul_p[PW-1:0]} + (PW+1)'(256);
   assign q30_round = {1'b0, mul_p} + (PRW+1)'(32'h2000_0000);

   assign div_t   = {rem_ff, dq_ff[DQW-1]};
   assign div_ge  = div_t >= {1'b0, wd_ff};
   assign div_rem = div_ge ? WD_BITS'(div_t - {1'b0, wd_ff}) : div_t[WD_BITS-1:0];
   assign div_dq  = {dq_ff[DQW-2:0], div_ge};
   assign nk      = (NK_W'(mul_p[WD_BITS+21:0]) << 32) + NK_W'(rk_ff);

   // shared position adder: x in S_MY_LO, y in S_POS_Y
   assign pos_old   = (state_ff == S_POS_Y) ? EW'(y_pos_ff) : EW'(x_pos_ff);
   assign pos_delta = EW'($signed({1'b0, scale_ff}));
   assign pos_sub   = (state_ff == S_POS_Y) ? (sum_neg_ff ^ c_neg_ff) : !(sum_neg_ff ^ s_neg_ff);
   assign pos_sum   = pos_sub ? pos_old - pos_delta : pos_old + pos_delta;

   assign t_round  = t_ff + 64'h8000_0000;
   assign turn_mag = t_round[63:32];
   assign turn     = diff_neg_ff ? -turn_mag : turn_mag;

   assign x_ext = EXT_W'(x_pos_ff);
   assign y_ext = EXT_W'(y_pos_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      upper_in = upper_ff;
      lower_in = lower_ff;
      dpp_in   = dpp_ff;
      wd_in    = wd_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_ENCODER_UPPER:      upper_in = csr_wdata[UPPER_BITS-1:0];
            REG_ENCODER_LOWER:      lower_in = csr_wdata[LOWER_BITS-1:0];
            REG_DISTANCE_PER_PULSE: dpp_in   = csr_wdata[DPP_BITS-1:0];
            REG_WHEEL_DISTANCE:     wd_in    = csr_wdata[WD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      iter_in       = iter_ff;
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      x_pos_in      = x_pos_ff;
      y_pos_in      = y_pos_ff;
      heading_in    = heading_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      sum_mag_in    = sum_mag_ff;
      diff_mag_in   = diff_mag_ff;
      sum_neg_in    = sum_neg_ff;
      diff_neg_in   = diff_neg_ff;
      rst_in        = rst_ff;
      dm_in         = dm_ff;
      n_mag_in      = n_mag_ff;
      fold_in       = fold_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      cz_in         = cz_ff;
      s_mag_in      = s_mag_ff;
      c_mag_in      = c_mag_ff;
      s_neg_in      = s_neg_ff;
      c_neg_in      = c_neg_ff;
      acc_in        = acc_ff;
      scale_in      = scale_ff;
      rem_in        = rem_ff;
      dq_in         = dq_ff;
      q_in          = q_ff;
      rk_in         = rk_ff;
      t_in          = t_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      mul_a         = MA'(sum_mag_ff);
      mul_b         = 32'(dpp_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               left_in  = req_tdata[COUNT_BITS-1:0];
               right_in = req_tdata[2*COUNT_BITS-1:COUNT_BITS];
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            sum_neg_in  = sum_v[SUM_W-1];
            diff_neg_in = diff_v[SUM_W-1];
            sum_mag_in  = sum_v[SUM_W-1] ? SUM_W'(-sum_v) : SUM_W'(sum_v);
            diff_mag_in = diff_v[SUM_W-1] ? SUM_W'(-diff_v) : SUM_W'(diff_v);
            rst_in      = near_limit(left_ff, upper_ff, lower_ff)
                          || near_limit(right_ff, upper_ff, lower_ff);
            fold_in     = heading_ff[31] ^ heading_ff[30];
            cz_in       = ANGLE_BITS'($signed(hr));
            cx_in       = CORDIC_X0;
            cy_in       = '0;
            state_in    = S_MUL_P;
         end
         S_MUL_P: begin
            dm_in    = p_round[PW:9];
            state_in = S_MUL_N;
         end
         S_MUL_N: begin
            mul_a    = MA'(diff_mag_ff);
            n_mag_in = mul_p[PW-1:0];
            iter_in  = '0;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            if (!cz_ff[ANGLE_BITS-1]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - atan_val;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + atan_val;
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == IW'(CORDIC_STEPS - 1)) begin
               state_in = S_TRIG;
            end
         end
         S_TRIG: begin
            s_neg_in = s_val[TRIG_BITS-1];
            c_neg_in = c_val[TRIG_BITS-1];
            s_mag_in = s_val[TRIG_BITS-1] ? 32'(-s_val) : 32'(s_val);
            c_mag_in = c_val[TRIG_BITS-1] ? 32'(-c_val) : 32'(c_val);
            state_in = S_MX_LO;
         end
         S_MX_LO: begin
            mul_a    = MA'(32'(dm_ff));
            mul_b    = s_mag_ff;
            acc_in   = q30_round[PRW:30];
            state_in = S_MX_HI;
         end
         S_MX_HI: begin
            mul_a    = MA'(dm_ff >> 32);
            mul_b    = s_mag_ff;
            scale_in = SW'({mul_p, 2'b00}) + SW'(acc_ff);
            state_in = S_MY_LO;
         end
         S_MY_LO: begin
            x_pos_in = sat_pos(pos_sum);
            mul_a    = MA'(32'(dm_ff));
            mul_b    = c_mag_ff;
            acc_in   = q30_round[PRW:30];
            state_in = S_MY_HI;
         end
         S_MY_HI: begin
            mul_a    = MA'(dm_ff >> 32);
            mul_b    = c_mag_ff;
            scale_in = SW'({mul_p, 2'b00}) + SW'(acc_ff);
            state_in = S_POS_Y;
         end
         S_POS_Y: begin
            y_pos_in = sat_pos(pos_sum);
            rem_in   = '0;
            dq_in    = DQW'(n_mag_ff) << (DQW - PW);
            iter_in  = '0;
            state_in = (wd_ff == '0) ? S_TURN : S_DIV1;
         end
         S_DIV1: begin
            rem_in  = div_rem;
            dq_in   = div_dq;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == IW'(PW - 1)) begin
               state_in = S_RK_LO;
            end
         end
         S_RK_LO: begin
            q_in     = dq_ff[PW-1:0];
            mul_a    = MA'(rem_ff);
            mul_b    = KF_LO;
            rk_in    = RK_W'(mul_p);
            state_in = S_RK_HI;
         end
         S_RK_HI: begin
            mul_a    = MA'(rem_ff);
            mul_b    = 32'(KF_HI);
            rem_in   = nk[NK_W-1:KF_QUOT_BITS];
            dq_in    = DQW'(nk[KF_QUOT_BITS-1:0]) << (DQW - KF_QUOT_BITS);
            iter_in  = '0;
            state_in = S_DIV2;
         end
         S_DIV2: begin
            rem_in  = div_rem;
            dq_in   = div_dq;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == IW'(KF_QUOT_BITS - 1)) begin
               state_in = S_QK0;
            end
         end
         S_QK0: begin
            mul_a    = MA'(32'(q_ff));
            mul_b    = KF_LO;
            t_in     = 64'(mul_p) + 64'(dq_ff[KF_QUOT_BITS-1:0]);
            state_in = S_QK1;
         end
         S_QK1: begin
            mul_a    = MA'(32'(q_ff));
            mul_b    = 32'(KF_HI);
            t_in     = t_ff + {mul_p[31:0], 32'd0};
            state_in = S_QK2;
         end
         S_QK2: begin
            mul_a    = MA'(q_ff >> 32);
            mul_b    = KF_LO;
            t_in     = t_ff + {mul_p[31:0], 32'd0};
            state_in = S_TURN;
         end
         S_TURN: begin
            if (wd_ff != '0) begin
               heading_in = heading_ff + turn;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = {heading_ff, y_ext[31:0], x_ext[31:0]};
               rsp_user_in   = rst_ff;
               prev_left_in  = rst_ff ? '0 : left_ff;
               prev_right_in = rst_ff ? '0 : right_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff      <= UPPER_RESET;
         lower_ff      <= LOWER_RESET;
         dpp_ff        <= DPP_RESET;
         wd_ff         <= WD_RESET;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         x_pos_ff      <= '0;
         y_pos_ff      <= '0;
         heading_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         iter_ff       <= '0;
      end else begin
         upper_ff      <= upper_in;
         lower_ff      <= lower_in;
         dpp_ff        <= dpp_in;
         wd_ff         <= wd_in;
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
         x_pos_ff      <= x_pos_in;
         y_pos_ff      <= y_pos_in;
         heading_ff    <= heading_in;
         rsp_valid_ff  <= rsp_valid_in;
         iter_ff       <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      right_ff    <= right_in;
      sum_mag_ff  <= sum_mag_in;
      diff_mag_ff <= diff_mag_in;
      sum_neg_ff  <= sum_neg_in;
      diff_neg_ff <= diff_neg_in;
      rst_ff      <= rst_in;
      dm_ff       <= dm_in;
      n_mag_ff    <= n_mag_in;
      fold_ff     <= fold_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      s_mag_ff    <= s_mag_in;
      c_mag_ff    <= c_mag_in;
      s_neg_ff    <= s_neg_in;
      c_neg_ff    <= c_neg_in;
      acc_ff      <= acc_in;
      scale_ff    <= scale_in;
      rem_ff      <= rem_in;
      dq_ff       <= dq_in;
      q_ff        <= q_in;
      rk_ff       <= rk_in;
      t_ff        <= t_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   `DDO_ASSERT_NOW(a_cordic_count, state_ff == S_CORDIC, iter_ff < IW'(CORDIC_STEPS), "cordic step count out of range")
   `DDO_ASSERT_NEXT(a_result_load, state_ff == S_DONE && (!rsp_valid_ff || rsp_tready), rsp_tvalid && req_tready, "result not presented after load")
   `DDO_ASSERT_NEXT(a_zero_wheel, state_ff == S_TURN && wd_ff == '0, $stable(heading_ff), "heading moved with zero wheel distance")

endmodule
